@@ src/bmpl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpl_pkg: shared types and constants for the Lucas binomial block
// Digit widths, the Pascal-triangle-mod-prime table, the mod-prime product
// table, the inter-cell link and the sequencer state type.
// ----------------------------------------------------------------------------
package bmpl_pkg;

  localparam int PRIME = 7;
  localparam int ARG_W = 64;
  localparam int CNT_W = $clog2(ARG_W);
  localparam int VW    = $clog2(PRIME);
  localparam int SW    = VW + 1;

  // Query modes
  localparam logic MODE_BINOM    = 1'b0;
  localparam logic MODE_MULTISET = 1'b1;

  // Base-PRIME digits needed to cover a full ARG_W-bit unsigned value
  function automatic int num_digits();
    logic [ARG_W-1:0] v;
    int               k;
    v = '1;
    k = 0;
    for (int i = 0; i < ARG_W; i++) begin
      if (v != '0) begin
        v = v / PRIME;
        k++;
      end
    end
    return k;
  endfunction

  localparam int NDIG = num_digits();

  typedef logic [PRIME-1:0][PRIME-1:0][VW-1:0] tab_t;

  function automatic tab_t build_pascal();
    tab_t t;
    t = '0;
    for (int a = 0; a < PRIME; a++) begin
      for (int b = 0; b < PRIME; b++) begin
        if (b > a) begin
          t[a][b] = '0;
        end else if (b == 0 || b == a) begin
          t[a][b] = VW'(1);
        end else begin
          t[a][b] = VW'((int'(t[a-1][b-1]) + int'(t[a-1][b])) % PRIME);
        end
      end
    end
    return t;
  endfunction

  function automatic tab_t build_mul();
    tab_t t;
    t = '0;
    for (int a = 0; a < PRIME; a++) begin
      for (int b = 0; b < PRIME; b++) begin
        t[a][b] = VW'((a * b) % PRIME);
      end
    end
    return t;
  endfunction

  localparam tab_t PASCAL_TAB = build_pascal();
  localparam tab_t MUL_TAB    = build_mul();

  // Data handed from one cell to the next
  typedef struct packed {
    logic          step;
    logic          top_bit;
    logic          bot_bit;
    logic          acc_vld;
    logic [VW-1:0] acc;
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DRAIN,
    ST_HOLD
  } state_t;

endpackage

@@ src/bmpl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpl_cell: one base-PRIME digit position
// Holds one digit of each argument, built by doubling as bits stream in,
// then folds its small binomial into the running product.
// ----------------------------------------------------------------------------
module bmpl_cell
  import bmpl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  clr,
  input  link_t link_in,
  output link_t link_out
);

  logic [VW-1:0] d_top_r;
  logic [VW-1:0] d_bot_r;
  logic [VW-1:0] d_top_nxt;
  logic [VW-1:0] d_bot_nxt;
  logic          c_top;
  logic          c_bot;
  logic [SW-1:0] s_top;
  logic [SW-1:0] s_bot;
  link_t         link_r;

  // digit * 2 + incoming carry, reduced once
  always_comb begin
    s_top = {d_top_r, link_in.top_bit};
    s_bot = {d_bot_r, link_in.bot_bit};
    c_top = (s_top >= SW'(PRIME));
    c_bot = (s_bot >= SW'(PRIME));
    d_top_nxt = c_top ? VW'(s_top - SW'(PRIME)) : VW'(s_top);
    d_bot_nxt = c_bot ? VW'(s_bot - SW'(PRIME)) : VW'(s_bot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.step    <= 1'b0;
      link_r.acc_vld <= 1'b0;
    end else begin
      link_r.step    <= link_in.step;
      link_r.acc_vld <= link_in.acc_vld;
    end
    link_r.top_bit <= c_top;
    link_r.bot_bit <= c_bot;
    link_r.acc     <= MUL_TAB[link_in.acc][PASCAL_TAB[d_top_r][d_bot_r]];
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      d_top_r <= '0;
      d_bot_r <= '0;
    end else if (link_in.step) begin
      d_top_r <= d_top_nxt;
      d_bot_r <= d_bot_nxt;
    end
  end

  assign link_out = link_r;

endmodule

@@ src/binomial_mod_prime_lucas.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_mod_prime_lucas: C(n, r) or C(n + r - 1, r) modulo PRIME
// Lucas's theorem over a row of digit cells fed one argument bit a cycle.
// ----------------------------------------------------------------------------
// One item at a time. An accepted item is streamed MSB first, one bit per
// cycle for all ARG_W bits, into a row of NDIG digit cells (23 for PRIME = 7)
// that convert both arguments to base PRIME by doubling; the carry and the
// running product then ripple one cell per cycle down the row, and the next
// item is taken only after the product has left the last cell and the result
// has passed on to the output register. An item whose answer is zero by
// range (negative r, n below r, or n <= 0 in multiset mode) skips the row.
// A finished item waits in the output register and the block goes back to
// accept while it waits.
module binomial_mod_prime_lucas
  import bmpl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic signed [ARG_W-1:0] in_n,
  input  logic signed [ARG_W-1:0] in_r,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [VW-1:0]           out_value
);

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [ARG_W-1:0] top_r;
  logic [ARG_W-1:0] bot_r;
  logic             kick_r;
  logic [VW-1:0]    res_r;
  logic             out_valid_r;
  logic [VW-1:0]    out_value_r;

  logic             in_acc;
  logic             out_free;
  logic             step;
  logic             clr;
  logic             last_bit;
  logic [ARG_W-1:0] n_u;
  logic [ARG_W-1:0] r_u;
  logic [ARG_W-1:0] sum;
  logic             zero;
  link_t            link [NDIG+1];

  assign n_u      = $unsigned(in_n);
  assign r_u      = $unsigned(in_r);
  assign sum      = n_u + r_u + '1;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_bit = (cnt_r == CNT_W'(ARG_W - 1));

  // Answer is zero by range alone: skip the cell row
  always_comb begin
    if (in_r[ARG_W-1] || in_n[ARG_W-1]) begin
      zero = 1'b1;
    end else if (in_mode == MODE_MULTISET) begin
      zero = (n_u == '0);
    end else begin
      zero = (n_u < r_u);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = zero ? ST_HOLD : ST_SHIFT;
      end
      ST_SHIFT: begin
        if (last_bit) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (link[NDIG].acc_vld) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    step     = 1'b0;
    clr      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        clr      = in_valid;
      end
      ST_SHIFT: step = 1'b1;
      ST_DRAIN: ;
      ST_HOLD:  ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kick_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kick_r  <= step && last_bit;
      if (state_r == ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      top_r <= (in_mode == MODE_MULTISET) ? sum : n_u;
      bot_r <= r_u;
      cnt_r <= '0;
      res_r <= '0;
    end else if (step) begin
      top_r <= {top_r[ARG_W-2:0], 1'b0};
      bot_r <= {bot_r[ARG_W-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (state_r == ST_DRAIN && link[NDIG].acc_vld) begin
      res_r <= link[NDIG].acc;
    end
    if (state_r == ST_HOLD && out_free) begin
      out_value_r <= res_r;
    end
  end

  // Head of the row: argument bits, MSB first, then the product seed
  always_comb begin
    link[0].step    = step;
    link[0].top_bit = top_r[ARG_W-1];
    link[0].bot_bit = bot_r[ARG_W-1];
    link[0].acc_vld = kick_r;
    link[0].acc     = VW'(1);
  end

  for (genvar k = 0; k < NDIG; k++) begin : g_cell
    bmpl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (clr),
      .link_in  (link[k]),
      .link_out (link[k+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

@@ sim/binomial_mod_prime_lucas_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_mod_prime_lucas_tb: self-checking bench for the Lucas binomial block
// Drives binomial and multiset queries through the valid/stall handshake,
// predicts each coefficient modulo PRIME by base-PRIME digit expansion and
// compares every result in order, under three patterns of sender and
// receiver idling.
// ----------------------------------------------------------------------------
module binomial_mod_prime_lucas_tb;
  import bmpl_pkg::*;

  localparam logic [ARG_W-1:0] ARG_MAX = {1'b0, {(ARG_W-1){1'b1}}};
  localparam logic [ARG_W-1:0] ARG_MIN = {1'b1, {(ARG_W-1){1'b0}}};

  // 22 base-PRIME digits stay below 2**63 for PRIME = 7
  localparam int MAX_DIGITS = 22;

  typedef struct {
    logic             mode;
    logic [ARG_W-1:0] n;
    logic [ARG_W-1:0] r;
    logic [VW-1:0]    value;
  } query_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_mode;
  logic signed [ARG_W-1:0] in_n;
  logic signed [ARG_W-1:0] in_r;
  logic                    out_valid;
  logic                    out_stall;
  logic [VW-1:0]           out_value;

  int unsigned pascal_mod [PRIME][PRIME];
  query_t      pending_coeffs [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int queries_sent;
  int multiset_sent;
  int nonzero_sent;

  binomial_mod_prime_lucas uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_n      (in_n),
    .in_r      (in_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Coefficient modulo PRIME by Lucas's theorem
  function automatic logic [VW-1:0] predict_coeff(input logic mode,
                                                  input logic [ARG_W-1:0] nv,
                                                  input logic [ARG_W-1:0] rv);
    logic [ARG_W-1:0] top;
    logic [ARG_W-1:0] bot;
    logic [ARG_W-1:0] base;
    int unsigned      acc;
    int unsigned      dt;
    int unsigned      db;
    base = ARG_W'(PRIME);
    if (rv[ARG_W-1]) return '0;
    if (mode == MODE_BINOM) begin
      if (nv[ARG_W-1] || nv < rv) return '0;
      top = nv;
    end else begin
      if (nv[ARG_W-1] || nv == '0) return '0;
      // both operands below 2**63, so the sum fits in 64 unsigned bits
      top = (nv - 1) + rv;
    end
    bot = rv;
    acc = 1;
    while (top != '0) begin
      dt  = int'(top % base);
      db  = int'(bot % base);
      acc = (acc * pascal_mod[dt][db]) % PRIME;
      top = top / base;
      bot = bot / base;
    end
    return VW'(acc);
  endfunction

  function automatic logic [ARG_W-1:0] rand_nonneg();
    logic [ARG_W-1:0] v;
    v = {$urandom, $urandom};
    v[ARG_W-1] = 1'b0;
    return v;
  endfunction

  // Build two numbers digit by digit; with dominant set every lower digit
  // stays at or below the upper one, so the coefficient is non-zero
  function automatic void make_digit_pair(input int ndig, input bit dominant,
                                          output logic [ARG_W-1:0] hi,
                                          output logic [ARG_W-1:0] lo);
    int unsigned dh;
    int unsigned dl;
    hi = '0;
    lo = '0;
    for (int i = 0; i < ndig; i++) begin
      dh = $urandom_range(PRIME - 1);
      dl = dominant ? $urandom_range(dh) : $urandom_range(PRIME - 1);
      hi = hi * PRIME + dh;
      lo = lo * PRIME + dl;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_query(input logic mode, input logic [ARG_W-1:0] nv,
                            input logic [ARG_W-1:0] rv);
    int     gap;
    query_t q;
    if ($urandom_range(99) < send_idle_pct) begin
      // mostly short gaps, now and then a much longer one
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 110) : $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      in_mode  <= logic'($urandom_range(1));
      in_n     <= {$urandom, $urandom};
      in_r     <= {$urandom, $urandom};
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_n     <= nv;
    in_r     <= rv;
    do @(posedge clk); while (in_stall);
    q.mode  = mode;
    q.n     = nv;
    q.r     = rv;
    q.value = predict_coeff(mode, nv, rv);
    pending_coeffs.push_back(q);
    queries_sent++;
    if (mode == MODE_MULTISET) multiset_sent++;
    if (q.value != '0) nonzero_sent++;
  endtask

  task automatic send_random_query(input bit any_mode, input logic pref_mode);
    logic [ARG_W-1:0] nv;
    logic [ARG_W-1:0] rv;
    logic [ARG_W-1:0] top;
    logic             mode;
    int               pick;
    mode = any_mode ? logic'($urandom_range(1)) : pref_mode;
    pick = $urandom_range(99);
    if (pick < 70) begin
      make_digit_pair($urandom_range(1, MAX_DIGITS), pick < 55, top, rv);
      // multiset: choose n so that n + r - 1 is the built upper number
      nv = (mode == MODE_MULTISET) ? top - rv + 1 : top;
    end else if (pick < 85) begin
      case ($urandom_range(4))
        0: begin nv = rand_nonneg(); rv = nv; end
        1: begin nv = rand_nonneg(); rv = '0; end
        2: begin rv = rand_nonneg() | 1; nv = rv - 1; end
        3: begin nv = ARG_W'($urandom_range(1)); rv = ARG_W'($urandom_range(3)); end
        default: begin nv = rand_nonneg(); rv = rand_nonneg(); end
      endcase
    end else begin
      mode = logic'($urandom_range(1));
      nv   = {$urandom, $urandom};
      rv   = {$urandom, $urandom};
    end
    send_query(mode, nv, rv);
  endtask

  task automatic test_corners();
    send_query(MODE_BINOM, '0, '0);
    send_query(MODE_BINOM, ARG_MAX, '0);
    send_query(MODE_BINOM, ARG_MAX, ARG_MAX);
    send_query(MODE_BINOM, ARG_MAX, ARG_MAX - 1);
    send_query(MODE_BINOM, 64'd6, 64'd3);
    // negative lower argument
    send_query(MODE_BINOM, 64'd5, '1);
    send_query(MODE_BINOM, ARG_MAX, ARG_MIN);
    send_query(MODE_BINOM, '1, '1);
    // upper below lower, and negative upper
    send_query(MODE_BINOM, 64'd3, 64'd4);
    send_query(MODE_BINOM, ARG_MIN, '0);
    // a digit of r above the matching digit of n, then no digit above
    send_query(MODE_BINOM, 64'd7, 64'd1);
    send_query(MODE_BINOM, 64'd342, 64'd300);
    send_query(MODE_MULTISET, '0, '0);
    send_query(MODE_MULTISET, 64'd1, '0);
    send_query(MODE_MULTISET, 64'd1, ARG_MAX);
    // sum well past 2**63
    send_query(MODE_MULTISET, ARG_MAX, ARG_MAX);
    send_query(MODE_MULTISET, ARG_MAX, '0);
    send_query(MODE_MULTISET, ARG_MAX, 64'd1);
    send_query(MODE_MULTISET, '1, 64'd3);
    send_query(MODE_MULTISET, ARG_MIN, ARG_MIN);
    send_query(MODE_MULTISET, 64'd5, -64'sd2);
    send_query(MODE_MULTISET, 64'd2, 64'd3);
  endtask

  task automatic test_binomial(input int count);
    repeat (count) send_random_query(1'b0, MODE_BINOM);
  endtask

  task automatic test_multiset(input int count);
    repeat (count) send_random_query(1'b0, MODE_MULTISET);
  endtask

  task automatic test_mixed(input int count);
    repeat (count) send_random_query(1'b1, MODE_BINOM);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    query_t q;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_coeffs.size() == 0) begin
        report_mismatch($sformatf("result %0d with no query outstanding", out_value));
      end else begin
        q = pending_coeffs.pop_front();
        if (out_value !== q.value) begin
          report_mismatch($sformatf("mode %0d n %0d r %0d: value %0d, want %0d",
                                    q.mode, $signed(q.n), $signed(q.r),
                                    out_value, q.value));
        end
      end
    end
  end

  initial begin
    for (int a = 0; a < PRIME; a++) begin
      for (int b = 0; b < PRIME; b++) begin
        if (b > a) begin
          pascal_mod[a][b] = 0;
        end else if (b == 0 || b == a) begin
          pascal_mod[a][b] = 1;
        end else begin
          pascal_mod[a][b] = (pascal_mod[a-1][b-1] + pascal_mod[a-1][b]) % PRIME;
        end
      end
    end
    mismatches     = 0;
    queries_sent   = 0;
    multiset_sent  = 0;
    nonzero_sent   = 0;
    send_idle_pct  = 26;
    recv_stall_pct = 81;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_mode   = MODE_BINOM;
    in_n      = '0;
    in_r      = '0;
    out_stall = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corners();
    test_binomial(200);
    send_idle_pct  = 81;
    recv_stall_pct = 26;
    test_multiset(200);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_mixed(200);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk);
    // leave room for any stray result
    repeat (120) @(posedge clk);

    $display("Checked %0d queries (%0d multiset, %0d with a non-zero coefficient)",
             queries_sent, multiset_sent, nonzero_sent);
    $display("under slow-receiver, slow-sender and back-to-back traffic");
    if (mismatches == 0) begin
      $display("binomial_mod_prime_lucas: match");
    end else begin
      $display("binomial_mod_prime_lucas: mismatch");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d results outstanding", pending_coeffs.size());
    $display("binomial_mod_prime_lucas: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
src/bmpl_pkg.sv
src/bmpl_cell.sv
src/binomial_mod_prime_lucas.sv
sim/binomial_mod_prime_lucas_tb.sv
